// File: hdl/tlv_stream_decoder_macros.svh
// ---------------------------------------------------------------------------
// TLV stream decoder assertion macros
// Short forms for the concurrent checks on the decoder ports.
// ---------------------------------------------------------------------------
`ifndef TLV_STREAM_DECODER_MACROS_SVH
`define TLV_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define TSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlv stream decoder check failed");

// Next-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define TSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlv stream decoder check failed");

`endif

// File: hdl/tsd_pkg.sv
// ---------------------------------------------------------------------------
// TLV stream decoder package
// Types and constants shared by the parser, the result queue and the top.
// ---------------------------------------------------------------------------
package tsd_pkg;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_LEN0  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LEN2A = 3'd3,
    PH_LEN2B = 3'd4,
    PH_VALUE = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_FORM   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_VALUE  = 2'd2
  } err_e;

  // First length byte values.
  localparam logic [7:0] LenLongFlag = 8'h80;
  localparam logic [7:0] LenOneByte  = 8'h81;
  localparam logic [7:0] LenTwoByte  = 8'h82;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag_value;
    logic [15:0] value_length;
    logic [7:0]  out_byte;
    err_e        error_code;
    logic        final_result;
  } result_t;

  // What the parser hands to the result queue for one byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage

// File: hdl/tsd_parser.sv
// ---------------------------------------------------------------------------
// TLV stream decoder parser
// Holds the element phase and decodes one byte into up to two results.
// ---------------------------------------------------------------------------
module tsd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 buffer_end_i,
  output tsd_pkg::parse_out_t  parse_o
);

  tsd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_tag_q, held_tag_d;
  logic [7:0]      length_high_q, length_high_d;
  logic [15:0]     remaining_q, remaining_d;

  function automatic tsd_pkg::result_t mk_header(logic [7:0] tag, logic [15:0] len,
                                                 logic fin);
    tsd_pkg::result_t r;
    r = '0;
    r.kind         = tsd_pkg::KIND_HEADER;
    r.tag_value    = tag;
    r.value_length = len;
    r.final_result = fin;
    return r;
  endfunction

  function automatic tsd_pkg::result_t mk_value(logic [7:0] b, logic fin);
    tsd_pkg::result_t r;
    r = '0;
    r.kind         = tsd_pkg::KIND_VALUE;
    r.out_byte     = b;
    r.final_result = fin;
    return r;
  endfunction

  function automatic tsd_pkg::result_t mk_error(tsd_pkg::err_e code);
    tsd_pkg::result_t r;
    r = '0;
    r.kind         = tsd_pkg::KIND_ERROR;
    r.error_code   = code;
    r.final_result = 1'b1;
    return r;
  endfunction

  logic [15:0] hdr_len;
  logic        hdr_now;
  logic [15:0] rem_dec;

  always_comb begin
    phase_d       = phase_q;
    held_tag_d    = held_tag_q;
    length_high_d = length_high_q;
    remaining_d   = remaining_q;
    parse_o       = '0;
    hdr_now       = 1'b0;
    hdr_len       = '0;
    rem_dec       = remaining_q - 16'd1;

    case (phase_q)
      tsd_pkg::PH_TAG: begin
        held_tag_d = in_byte_i;
        if (buffer_end_i) begin
          parse_o.count = 2'd1;
          parse_o.first = mk_error(tsd_pkg::ERR_HEADER);
        end else begin
          phase_d = tsd_pkg::PH_LEN0;
        end
      end
      tsd_pkg::PH_LEN0: begin
        if (in_byte_i < tsd_pkg::LenLongFlag) begin
          hdr_now = 1'b1;
          hdr_len = {8'd0, in_byte_i};
        end else if (in_byte_i == tsd_pkg::LenOneByte ||
                     in_byte_i == tsd_pkg::LenTwoByte) begin
          if (buffer_end_i) begin
            parse_o.count = 2'd1;
            parse_o.first = mk_error(tsd_pkg::ERR_HEADER);
            phase_d       = tsd_pkg::PH_TAG;
          end else if (in_byte_i == tsd_pkg::LenOneByte) begin
            phase_d = tsd_pkg::PH_LEN1;
          end else begin
            phase_d = tsd_pkg::PH_LEN2A;
          end
        end else begin
          parse_o.count = 2'd1;
          parse_o.first = mk_error(tsd_pkg::ERR_FORM);
          phase_d       = buffer_end_i ? tsd_pkg::PH_TAG : tsd_pkg::PH_SKIP;
        end
      end
      tsd_pkg::PH_LEN1: begin
        hdr_now = 1'b1;
        hdr_len = {8'd0, in_byte_i};
      end
      tsd_pkg::PH_LEN2A: begin
        length_high_d = in_byte_i;
        if (buffer_end_i) begin
          parse_o.count = 2'd1;
          parse_o.first = mk_error(tsd_pkg::ERR_HEADER);
          phase_d       = tsd_pkg::PH_TAG;
        end else begin
          phase_d = tsd_pkg::PH_LEN2B;
        end
      end
      tsd_pkg::PH_LEN2B: begin
        hdr_now = 1'b1;
        hdr_len = {length_high_q, in_byte_i};
      end
      tsd_pkg::PH_VALUE: begin
        remaining_d = rem_dec;
        if (rem_dec == 16'd0) begin
          parse_o.count = 2'd1;
          parse_o.first = mk_value(in_byte_i, 1'b1);
          phase_d       = buffer_end_i ? tsd_pkg::PH_TAG : tsd_pkg::PH_SKIP;
        end else if (buffer_end_i) begin
          parse_o.count  = 2'd2;
          parse_o.first  = mk_value(in_byte_i, 1'b0);
          parse_o.second = mk_error(tsd_pkg::ERR_VALUE);
          remaining_d    = '0;
          phase_d        = tsd_pkg::PH_TAG;
        end else begin
          parse_o.count = 2'd1;
          parse_o.first = mk_value(in_byte_i, 1'b0);
        end
      end
      default: begin
        phase_d = buffer_end_i ? tsd_pkg::PH_TAG : tsd_pkg::PH_SKIP;
      end
    endcase

    // The length is complete: header, then either nothing, the value, or an error.
    if (hdr_now) begin
      remaining_d = '0;
      if (hdr_len == 16'd0) begin
        parse_o.count = 2'd1;
        parse_o.first = mk_header(held_tag_q, 16'd0, 1'b1);
        phase_d       = buffer_end_i ? tsd_pkg::PH_TAG : tsd_pkg::PH_SKIP;
      end else if (buffer_end_i) begin
        parse_o.count  = 2'd2;
        parse_o.first  = mk_header(held_tag_q, hdr_len, 1'b0);
        parse_o.second = mk_error(tsd_pkg::ERR_VALUE);
        phase_d        = tsd_pkg::PH_TAG;
      end else begin
        parse_o.count = 2'd1;
        parse_o.first = mk_header(held_tag_q, hdr_len, 1'b0);
        remaining_d   = hdr_len;
        phase_d       = tsd_pkg::PH_VALUE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tsd_pkg::PH_TAG;
      held_tag_q    <= '0;
      length_high_q <= '0;
      remaining_q   <= '0;
    end else if (take_i) begin
      phase_q       <= phase_d;
      held_tag_q    <= held_tag_d;
      length_high_q <= length_high_d;
      remaining_q   <= remaining_d;
    end
  end

endmodule

// File: hdl/tsd_result_queue.sv
// ---------------------------------------------------------------------------
// TLV stream decoder result queue
// Four-entry register queue; takes up to two results a cycle, gives one while out_ready_i is high.
// ---------------------------------------------------------------------------
module tsd_result_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tsd_pkg::parse_out_t  parse_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tsd_pkg::result_t     head_o
);

  tsd_pkg::result_t entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;
  logic [1:0] n_push;

  assign out_valid_o = (count_q != 3'd0);
  assign head_o      = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for the worst case of two results from the next byte.
  assign room_o      = (count_q <= 3'd2);
  assign n_push      = push_i ? parse_i.count : 2'd0;

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entry_q[wr_ptr_q] <= parse_i.first;
    end
    if (n_push == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= parse_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hdl/tlv_stream_decoder.sv
// ---------------------------------------------------------------------------
// TLV stream decoder
// Decodes one-byte-tag BER-TLV elements from a byte stream into header,
// value byte and error words.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | in_valid_i/in_ready_o  | in_byte_i, buffer_end_i
//   out     | source    | out_valid_o/out_ready_i| kind, tag, length, byte,
//           |           |                        | error code, final flag
//
// One input word is taken per cycle while in_ready_o is high. Each word produces
// zero, one or two result words, written into a four-entry result queue at the
// edge that takes the word; the first result is on the output in the next cycle
// if the queue was empty. The queue drains one word per cycle while out_ready_i
// is high, so two-result words (a header or value byte followed by a truncation
// error) fill two entries. in_ready_o drops while the queue holds three or more
// words, so an output stall backs up into the input after at most four pending
// results. rst_ni clears the parse phase and empties the queue asynchronously.
//
// The parser keeps the phase of the current element (tag, length bytes,
// value, skip to end of buffer) and the value byte count. Each accepted word
// walks the phase by one step through short logic. A word
// marked buffer_end always returns the phase to expecting a tag.
module tlv_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tag_value_o,
  output logic [15:0] value_length_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  error_code_o,
  output logic        final_result_o
);

  tsd_pkg::parse_out_t parse;
  tsd_pkg::result_t    head;
  logic                take;

  // A valid word is taken when the queue can absorb the worst case of two results.
  assign take = in_valid_i && in_ready_o;

  tsd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .in_byte_i    (in_byte_i),
    .buffer_end_i (buffer_end_i),
    .parse_o      (parse)
  );

  tsd_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .parse_i     (parse),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // Unused fields of each word are zero, as built by the parser.
  assign kind_o         = head.kind;
  assign tag_value_o    = head.tag_value;
  assign value_length_o = head.value_length;
  assign out_byte_o     = head.out_byte;
  assign error_code_o   = head.error_code;
  assign final_result_o = head.final_result;

endmodule

// File: hdl/tsd_checker.sv
// ---------------------------------------------------------------------------
// TLV stream decoder checker
// Port-level checks on the result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "tlv_stream_decoder_macros.svh"

module tsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        buffer_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  tag_value_o,
  input logic [15:0] value_length_o,
  input logic [7:0]  out_byte_o,
  input logic [1:0]  error_code_o,
  input logic        final_result_o
);

  logic is_value;
  logic is_error;
  logic is_header;

  assign is_value  = out_valid_o && (kind_o == tsd_pkg::KIND_VALUE);
  assign is_error  = out_valid_o && (kind_o == tsd_pkg::KIND_ERROR);
  assign is_header = out_valid_o && (kind_o == tsd_pkg::KIND_HEADER);

  `TSD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(out_byte_o) && $stable(final_result_o))
  `TSD_ASSERT_NOW(a_error_final, is_error, final_result_o && tag_value_o == 8'd0 && value_length_o == 16'd0)
  `TSD_ASSERT_NOW(a_value_clean, is_value, tag_value_o == 8'd0 && value_length_o == 16'd0 && error_code_o == tsd_pkg::ERR_FORM)
  `TSD_ASSERT_NOW(a_empty_header_final, is_header && value_length_o == 16'd0, final_result_o)

endmodule

bind tlv_stream_decoder tsd_checker u_tsd_checker (.*);
